FILE: design/gqv_pkg.sv
// ============================================================================
// gqv_pkg
// Shared types, codes and helpers for the glyph quad vertex generator.
// ============================================================================
`default_nettype none

package gqv_pkg;

    // Defaults for the top-level parameters
    localparam int GLYPH_COUNT_DEF  = 96;
    localparam int GLYPH_HEIGHT_DEF = 16;

    // Field widths
    localparam int POS_W   = 20;
    localparam int U_W     = 17;
    localparam int WIDTH_W = 8;
    localparam int SUM_W   = 22;   // pen arithmetic before saturation

    // Request kinds
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_CHAR  = 2'd2;

    // Stage-1 operations
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_SPACE = 2'd2;
    localparam logic [1:0] OP_GLYPH = 2'd3;

    // Character codes
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_FIRST = 8'd33;
    localparam logic [7:0] CHAR_LAST  = 8'd126;

    // Pen advance for a space: three pixels, 4 fraction bits
    localparam logic signed [SUM_W-1:0] SPACE_OFS = 22'sd48;

    // Vertex order TL, BR, BL, TL, TR, BR; bit i belongs to vertex i
    localparam logic [5:0] VTX_RIGHT  = 6'b110010;
    localparam logic [5:0] VTX_BOTTOM = 6'b100110;
    localparam logic [2:0] VTX_LAST   = 3'd5;

    typedef struct packed {
        logic [U_W-1:0]     left;
        logic [U_W-1:0]     right;
        logic [WIDTH_W-1:0] width;
    } glyph_t;

    localparam int GLYPH_W = $bits(glyph_t);

    typedef struct packed {
        logic signed [POS_W-1:0] xl;
        logic signed [POS_W-1:0] xr;
        logic signed [POS_W-1:0] yt;
        logic signed [POS_W-1:0] yb;
        logic [U_W-1:0]          u_left;
        logic [U_W-1:0]          u_right;
    } quad_t;

    // Clamp to the signed 20-bit position range
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > 22'sd524287)
            r = 20'sh7FFFF;
        else if (v < -22'sd524288)
            r = 20'sh80000;
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

    function automatic logic signed [SUM_W-1:0] ext_pos(input logic signed [POS_W-1:0] v);
        return $signed({{(SUM_W-POS_W){v[POS_W-1]}}, v});
    endfunction

endpackage

`default_nettype wire

FILE: design/gqv_if.sv
// ============================================================================
// gqv channel interfaces
// Text request channel and vertex result channel, valid/ready handshake.
// ============================================================================
`default_nettype none

interface gqv_in_if;
    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic [6:0]          glyph_slot;
    logic [16:0]         glyph_left;
    logic [16:0]         glyph_right;
    logic [7:0]          glyph_width;
    logic signed [19:0]  start_x;
    logic signed [19:0]  start_y;
    logic [7:0]          char_code;

    modport source (output valid, kind, glyph_slot, glyph_left, glyph_right,
                    glyph_width, start_x, start_y, char_code, input ready);
    modport sink   (input valid, kind, glyph_slot, glyph_left, glyph_right,
                    glyph_width, start_x, start_y, char_code, output ready);
endinterface

interface gqv_out_if;
    logic                valid;
    logic                ready;
    logic signed [19:0]  vertex_x;
    logic signed [19:0]  vertex_y;
    logic [16:0]         tex_u;
    logic                tex_v;
    logic                last_vertex;

    modport source (output valid, vertex_x, vertex_y, tex_u, tex_v, last_vertex,
                    input ready);
    modport sink   (input valid, vertex_x, vertex_y, tex_u, tex_v, last_vertex,
                    output ready);
endinterface

`default_nettype wire

FILE: design/gqv_ram.sv
// ============================================================================
// gqv_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module gqv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: design/gqv_emit.sv
// ============================================================================
// gqv_emit
// Quad buffer and vertex sequencer: six vertices per quad into an output
// register.
// ============================================================================
`default_nettype none

module gqv_emit
    import gqv_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  quad_valid,
    output      logic  quad_ready,
    input  wire quad_t quad,
    gqv_out_if.source  vertex_out
);

    quad_t      quad_reg;
    logic       busy_reg, busy_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       adv;
    logic       take_quad;
    logic       sel_right, sel_bottom;

    logic signed [POS_W-1:0] vx_reg, vy_reg;
    logic [U_W-1:0]          u_reg;
    logic                    v_reg, last_reg;

    assign adv        = busy_reg && (!out_valid_reg || vertex_out.ready);
    assign quad_ready = !busy_reg || (adv && cnt_reg == VTX_LAST);
    assign take_quad  = quad_valid && quad_ready;
    assign sel_right  = VTX_RIGHT[cnt_reg];
    assign sel_bottom = VTX_BOTTOM[cnt_reg];

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (adv)
        begin
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == VTX_LAST)
                busy_next = 1'b0;
        end
        if (take_quad)
        begin
            busy_next = 1'b1;
            cnt_next  = 3'd0;
        end
        if (adv)
            out_valid_next = 1'b1;
        else if (vertex_out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_quad)
            quad_reg <= quad;
        if (adv)
        begin
            vx_reg   <= sel_right  ? quad_reg.xr : quad_reg.xl;
            vy_reg   <= sel_bottom ? quad_reg.yb : quad_reg.yt;
            u_reg    <= sel_right  ? quad_reg.u_right : quad_reg.u_left;
            v_reg    <= sel_bottom;
            last_reg <= (cnt_reg == VTX_LAST);
        end
    end

    assign vertex_out.valid       = out_valid_reg;
    assign vertex_out.vertex_x    = vx_reg;
    assign vertex_out.vertex_y    = vy_reg;
    assign vertex_out.tex_u       = u_reg;
    assign vertex_out.tex_v       = v_reg;
    assign vertex_out.last_vertex = last_reg;

`ifndef SYNTH
    // A new quad only lands on an idle sequencer or as the last vertex leaves
    a_quad_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        take_quad |-> (!busy_reg || cnt_reg == VTX_LAST))
        else $error("quad taken mid-sequence");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg <= VTX_LAST)
        else $error("vertex counter out of range");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && cnt_reg == VTX_LAST) |=> (out_valid_reg && last_reg))
        else $error("sixth vertex not marked last");
`endif

endmodule

`default_nettype wire

FILE: design/glyph_quad_vertex_generator.sv
// ============================================================================
// glyph_quad_vertex_generator
// Turns text requests into textured quad vertices from a glyph table and pen.
// ============================================================================
//
//  channel     dir  payload                                    handshake
//  ----------  ---  -----------------------------------------  -----------
//  text_in     in   kind, glyph_slot, glyph_left/right/width,  valid/ready
//                   start_x, start_y, char_code
//  vertex_out  out  vertex_x, vertex_y, tex_u, tex_v,          valid/ready
//                   last_vertex
//
//  A request is taken every cycle unless a printable character waits in
//  stage 1 for the vertex sequencer; a character yields six vertices in turn
//  on the single result port, and the sequencer takes the next quad only as
//  its last vertex leaves. Loads, starts, spaces and ignored codes never wait.
//  A character goes request edge -> glyph read -> quad/pen update -> first
//  vertex registered; the quad waits in stage 1 while the sequencer is busy.
//  Reset clears pen and control state; glyph table contents are undefined
//  until loaded. A stalled result port holds the output register and backs
//  up through the sequencer into stage 1 and then text_in.ready.
//
// ============================================================================
`default_nettype none

module glyph_quad_vertex_generator
    import gqv_pkg::*;
#(
    parameter int GLYPH_COUNT  = GLYPH_COUNT_DEF,
    parameter int GLYPH_HEIGHT = GLYPH_HEIGHT_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    gqv_in_if.sink     text_in,
    gqv_out_if.source  vertex_out
);

    localparam int AW = $clog2(GLYPH_COUNT);
    // Glyph height in position units (4 fraction bits)
    localparam logic signed [SUM_W-1:0] HEIGHT_OFS = SUM_W'(GLYPH_HEIGHT * 16);

    // ---------------------------------------------------------------- stage 0
    logic             accept;
    logic [7:0]       char_slot;
    logic             slot_ok;
    logic             char_ok;
    logic [1:0]       op_in;
    logic             ram_we, ram_re;
    logic [GLYPH_W-1:0] ram_wdata, ram_rdata;

    assign accept    = text_in.valid && text_in.ready;
    assign char_slot = text_in.char_code - CHAR_SPACE;
    assign slot_ok   = {1'b0, text_in.glyph_slot} < 8'(GLYPH_COUNT);
    assign char_ok   = (text_in.char_code inside {[CHAR_FIRST:CHAR_LAST]}) &&
                       (char_slot < 8'(GLYPH_COUNT));

    always_comb
    begin
        op_in = OP_NONE;
        case (text_in.kind)
            KIND_START: op_in = OP_START;
            KIND_CHAR:
            begin
                if (text_in.char_code == CHAR_SPACE)
                    op_in = OP_SPACE;
                else if (char_ok)
                    op_in = OP_GLYPH;
            end
            default:    op_in = OP_NONE;
        endcase
    end

    // Load writes on its own accept edge; any later character reads after
    // it, so a read never meets a write to the same entry in one cycle.
    assign ram_we    = accept && (text_in.kind == KIND_LOAD) && slot_ok;
    assign ram_re    = accept && (op_in == OP_GLYPH);
    assign ram_wdata = {text_in.glyph_left, text_in.glyph_right, text_in.glyph_width};

    gqv_ram #(
        .WIDTH (GLYPH_W),
        .DEPTH (GLYPH_COUNT)
    ) u_glyph_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (text_in.glyph_slot[AW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (char_slot[AW-1:0]),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------- stage 1
    // Holds the request while the glyph entry comes out of the RAM; the pen
    // is only touched here so starts and advances stay in request order.
    logic                    s1_valid_reg;
    logic [1:0]              s1_op_reg;
    logic signed [POS_W-1:0] s1_x_reg, s1_y_reg;
    logic signed [POS_W-1:0] pen_x_reg, pen_x_next;
    logic signed [POS_W-1:0] pen_y_reg, pen_y_next;
    logic                    s1_advance;
    logic                    quad_valid, quad_ready;
    glyph_t                  glyph;
    quad_t                   quad;
    logic signed [SUM_W-1:0] pen_x_ext, w_ofs, w1_ofs;

    assign glyph      = glyph_t'(ram_rdata);
    assign quad_valid = s1_valid_reg && (s1_op_reg == OP_GLYPH);
    assign s1_advance = s1_valid_reg && ((s1_op_reg != OP_GLYPH) || quad_ready);
    assign text_in.ready = !s1_valid_reg || s1_advance;

    assign pen_x_ext = ext_pos(pen_x_reg);
    assign w_ofs     = $signed({{(SUM_W-WIDTH_W-4){1'b0}}, glyph.width, 4'b0000});
    assign w1_ofs    = w_ofs + 22'sd16;

    assign quad.xl      = pen_x_reg;
    assign quad.xr      = sat_pos(pen_x_ext + w_ofs);
    assign quad.yt      = pen_y_reg;
    assign quad.yb      = sat_pos(ext_pos(pen_y_reg) - HEIGHT_OFS);
    assign quad.u_left  = glyph.left;
    assign quad.u_right = glyph.right;

    always_comb
    begin
        pen_x_next = pen_x_reg;
        pen_y_next = pen_y_reg;
        if (s1_advance)
        begin
            case (s1_op_reg)
                OP_START:
                begin
                    pen_x_next = s1_x_reg;
                    pen_y_next = s1_y_reg;
                end
                OP_SPACE: pen_x_next = sat_pos(pen_x_ext + SPACE_OFS);
                OP_GLYPH: pen_x_next = sat_pos(pen_x_ext + w1_ofs);
                default:  pen_x_next = pen_x_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_op_reg    <= OP_NONE;
            pen_x_reg    <= '0;
            pen_y_reg    <= '0;
        end
        else
        begin
            pen_x_reg <= pen_x_next;
            pen_y_reg <= pen_y_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                s1_op_reg    <= op_in;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg <= text_in.start_x;
            s1_y_reg <= text_in.start_y;
        end
    end

    // ---------------------------------------------------------------- output
    gqv_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .quad_valid (quad_valid),
        .quad_ready (quad_ready),
        .quad       (quad),
        .vertex_out (vertex_out)
    );

endmodule

`default_nettype wire
